/* design/icm_pkg.sv */
// Package for the innovation consistency monitor: widths, constants, operand codes,
// state and control types, and the multiply-term schedule.
// No dependencies; every other design file imports it.
package icm_pkg;

  localparam int LIMB_W     = 32;
  localparam int ACC_W      = 192;
  localparam int AMAG_W     = 96;
  localparam int BMAG_W     = 64;
  localparam int S_W        = 34;
  localparam int C_W        = 72;
  localparam int P_W        = 64;
  localparam int NIS_W      = 40;
  localparam int QUOT_W     = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_TERMS  = 27;
  localparam int TERM_IDX_W = 5;

  localparam logic [NIS_W-1:0] SINGULAR_NIS = 40'd65536000000;
  localparam logic [ACC_W-1:0] DET_EPS_RAW  = 192'd281;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_XX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_XY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_XZ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_YY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_YZ   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ZZ   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NIS_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIS_LIMIT = 3'd7;

  typedef enum logic [4:0] {
    OP_SXX, OP_SXY, OP_SXZ, OP_SYY, OP_SYZ, OP_SZZ,
    OP_EX, OP_EY, OP_EZ,
    OP_C00, OP_C01, OP_C02, OP_C11, OP_C12, OP_C22,
    OP_PXX, OP_PYY, OP_PZZ, OP_PXY, OP_PXZ, OP_PYZ,
    OP_DET, OP_NUM
  } opnd_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TERM_START, ST_TERM_WAIT, ST_TERM_NEXT, ST_CHECK, ST_DIV_WAIT,
    ST_WIN_READ, ST_WIN_WRITE, ST_AVG_START, ST_AVG_WAIT, ST_FINISH
  } state_e;

  typedef struct packed {
    opnd_e a_sel;
    opnd_e b_sel;
    logic  neg;
    logic  dbl;
    logic  first;
    logic  last;
    opnd_e dest;
  } term_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic dbl;
    logic first;
  } mac_cmd_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } win_ctrl_t;

  // Schedule of signed product terms: cofactors, determinant, innovation
  // products, then the quadratic form.
  function automatic term_t term_entry(input logic [TERM_IDX_W-1:0] idx);
    term_t t;
    t = '{OP_SXX, OP_SXX, 1'b0, 1'b0, 1'b1, 1'b1, OP_NUM};
    unique case (idx)
      5'd0:  t = '{OP_SYY, OP_SZZ, 1'b0, 1'b0, 1'b1, 1'b0, OP_C00};
      5'd1:  t = '{OP_SYZ, OP_SYZ, 1'b1, 1'b0, 1'b0, 1'b1, OP_C00};
      5'd2:  t = '{OP_SXZ, OP_SYZ, 1'b0, 1'b0, 1'b1, 1'b0, OP_C01};
      5'd3:  t = '{OP_SXY, OP_SZZ, 1'b1, 1'b0, 1'b0, 1'b1, OP_C01};
      5'd4:  t = '{OP_SXY, OP_SYZ, 1'b0, 1'b0, 1'b1, 1'b0, OP_C02};
      5'd5:  t = '{OP_SXZ, OP_SYY, 1'b1, 1'b0, 1'b0, 1'b1, OP_C02};
      5'd6:  t = '{OP_SXX, OP_SZZ, 1'b0, 1'b0, 1'b1, 1'b0, OP_C11};
      5'd7:  t = '{OP_SXZ, OP_SXZ, 1'b1, 1'b0, 1'b0, 1'b1, OP_C11};
      5'd8:  t = '{OP_SXZ, OP_SXY, 1'b0, 1'b0, 1'b1, 1'b0, OP_C12};
      5'd9:  t = '{OP_SXX, OP_SYZ, 1'b1, 1'b0, 1'b0, 1'b1, OP_C12};
      5'd10: t = '{OP_SXX, OP_SYY, 1'b0, 1'b0, 1'b1, 1'b0, OP_C22};
      5'd11: t = '{OP_SXY, OP_SXY, 1'b1, 1'b0, 1'b0, 1'b1, OP_C22};
      5'd12: t = '{OP_C00, OP_SXX, 1'b0, 1'b0, 1'b1, 1'b0, OP_DET};
      5'd13: t = '{OP_C01, OP_SXY, 1'b0, 1'b0, 1'b0, 1'b0, OP_DET};
      5'd14: t = '{OP_C02, OP_SXZ, 1'b0, 1'b0, 1'b0, 1'b1, OP_DET};
      5'd15: t = '{OP_EX,  OP_EX,  1'b0, 1'b0, 1'b1, 1'b1, OP_PXX};
      5'd16: t = '{OP_EY,  OP_EY,  1'b0, 1'b0, 1'b1, 1'b1, OP_PYY};
      5'd17: t = '{OP_EZ,  OP_EZ,  1'b0, 1'b0, 1'b1, 1'b1, OP_PZZ};
      5'd18: t = '{OP_EX,  OP_EY,  1'b0, 1'b0, 1'b1, 1'b1, OP_PXY};
      5'd19: t = '{OP_EX,  OP_EZ,  1'b0, 1'b0, 1'b1, 1'b1, OP_PXZ};
      5'd20: t = '{OP_EY,  OP_EZ,  1'b0, 1'b0, 1'b1, 1'b1, OP_PYZ};
      5'd21: t = '{OP_C00, OP_PXX, 1'b0, 1'b0, 1'b1, 1'b0, OP_NUM};
      5'd22: t = '{OP_C11, OP_PYY, 1'b0, 1'b0, 1'b0, 1'b0, OP_NUM};
      5'd23: t = '{OP_C22, OP_PZZ, 1'b0, 1'b0, 1'b0, 1'b0, OP_NUM};
      5'd24: t = '{OP_C01, OP_PXY, 1'b0, 1'b1, 1'b0, 1'b0, OP_NUM};
      5'd25: t = '{OP_C02, OP_PXZ, 1'b0, 1'b1, 1'b0, 1'b0, OP_NUM};
      5'd26: t = '{OP_C12, OP_PYZ, 1'b0, 1'b1, 1'b0, 1'b1, OP_NUM};
      default: t = '{OP_SXX, OP_SXX, 1'b0, 1'b0, 1'b1, 1'b1, OP_NUM};
    endcase
    return t;
  endfunction

endpackage

/* design/icm_mac.sv */
// Shared multiply-accumulate unit: one 32x32 limb multiplier builds a signed product
// term limb by limb and adds it into a 192-bit accumulator.
// Depends on icm_pkg.
module icm_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  icm_pkg::mac_cmd_t                    cmd_i,
  input  logic signed [icm_pkg::AMAG_W-1:0]    a_i,
  input  logic signed [icm_pkg::BMAG_W-1:0]    b_i,
  output logic                                 done_o,
  output logic        [icm_pkg::ACC_W-1:0]     acc_o
);
  import icm_pkg::*;

  logic                    busy_q, pv_q, done_q;
  logic [2:0]              cnt_q;
  logic [AMAG_W-1:0]       ma_q;
  logic [BMAG_W-1:0]       mb_q;
  logic                    neg_q, dbl_q, first_q;
  logic [2*LIMB_W-1:0]     prod_q;
  logic [1:0]              psh_q;
  logic [ACC_W-1:0]        pacc_q, acc_q;

  logic [LIMB_W-1:0]       limb_a, limb_b;
  logic [2*LIMB_W-1:0]     mul_w;
  logic [ACC_W-1:0]        shifted, term, sterm, base;
  logic [AMAG_W-1:0]       mag_a;
  logic [BMAG_W-1:0]       mag_b;

  always_comb begin
    case (cnt_q[2:1])
      2'd0:    limb_a = ma_q[LIMB_W-1:0];
      2'd1:    limb_a = ma_q[2*LIMB_W-1:LIMB_W];
      2'd2:    limb_a = ma_q[3*LIMB_W-1:2*LIMB_W];
      default: limb_a = '0;
    endcase
    limb_b  = cnt_q[0] ? mb_q[2*LIMB_W-1:LIMB_W] : mb_q[LIMB_W-1:0];
    mul_w   = limb_a * limb_b;
    shifted = {{(ACC_W-2*LIMB_W){1'b0}}, prod_q} << {psh_q, 5'b00000};
    term    = dbl_q ? {pacc_q[ACC_W-2:0], 1'b0} : pacc_q;
    sterm   = neg_q ? (~term + ACC_W'(1)) : term;
    base    = first_q ? '0 : acc_q;
    mag_a   = a_i[AMAG_W-1] ? AMAG_W'(-a_i) : AMAG_W'(a_i);
    mag_b   = b_i[BMAG_W-1] ? BMAG_W'(-b_i) : BMAG_W'(b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        pv_q   <= 1'b0;
      end else if (busy_q) begin
        pv_q <= (cnt_q < 3'd6);
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ma_q    <= mag_a;
      mb_q    <= mag_b;
      neg_q   <= cmd_i.neg ^ a_i[AMAG_W-1] ^ b_i[BMAG_W-1];
      dbl_q   <= cmd_i.dbl;
      first_q <= cmd_i.first;
      pacc_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd6) begin
        prod_q <= mul_w;
        psh_q  <= cnt_q[2:1] + {1'b0, cnt_q[0]};
      end
      if (pv_q) begin
        pacc_q <= pacc_q + shifted;
      end
      if (cnt_q == 3'd7) begin
        acc_q <= base + sterm;
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

/* design/icm_divider.sv */
// Shared restoring divider: 40-bit quotient of two unsigned 192-bit values,
// one bit per cycle, saturating when the quotient does not fit.
// Depends on icm_pkg.
module icm_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [icm_pkg::ACC_W-1:0]       num_i,
  input  logic [icm_pkg::ACC_W-1:0]       den_i,
  output logic                            done_o,
  output logic [icm_pkg::QUOT_W-1:0]      quot_o
);
  import icm_pkg::*;

  logic              busy_q, done_q;
  logic [5:0]        cnt_q;
  logic [ACC_W-1:0]  r_q, d_q, dn;
  logic [QUOT_W-1:0] q_q;
  logic              ge_full, ge_step;

  assign dn      = d_q >> 1;
  assign ge_full = (r_q >= d_q);
  assign ge_step = (r_q >= dn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if ((cnt_q == 6'd0 && ge_full) || cnt_q == 6'(QUOT_W)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= num_i;
      d_q <= den_i << QUOT_W;
      q_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        if (ge_full) begin
          q_q <= '1;
        end
      end else begin
        d_q <= dn;
        if (ge_step) begin
          r_q <= r_q - dn;
          q_q <= {q_q[QUOT_W-2:0], 1'b1};
        end else begin
          q_q <= {q_q[QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

/* design/icm_window.sv */
// Sliding window of recent NIS values: entry memory, head pointer, fill count
// and running sum.
// Depends on icm_pkg.
module icm_window #(
  parameter  int DEPTH  = 16,
  localparam int FILL_W = $clog2(DEPTH + 1),
  localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int SUM_W  = icm_pkg::NIS_W + $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  icm_pkg::win_ctrl_t          ctrl_i,
  input  logic [icm_pkg::NIS_W-1:0]   nis_i,
  output logic [SUM_W-1:0]            sum_o,
  output logic [FILL_W-1:0]           fill_o
);
  import icm_pkg::*;

  logic [NIS_W-1:0]  mem_q [DEPTH];
  logic [NIS_W-1:0]  rdata_q;
  logic [HEAD_W-1:0] head_q;
  logic [FILL_W-1:0] fill_q;
  logic [SUM_W-1:0]  sum_q;
  logic              full;

  assign full = (fill_q == FILL_W'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[head_q];
    end
    if (ctrl_i.wr) begin
      mem_q[head_q] <= nis_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.wr) begin
      sum_q <= sum_q - (full ? SUM_W'(rdata_q) : '0) + SUM_W'(nis_i);
      if (!full) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      head_q <= (head_q == HEAD_W'(DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

/* design/innovation_consistency_monitor.sv */
// Top level of the innovation consistency monitor: configuration registers, the
// sequencer and the operand file around the shared multiplier and divider.
// Depends on icm_pkg, icm_mac, icm_divider and icm_window.

// No new item is accepted while an item is in progress, from acceptance to result. Most
// of the work goes to 27 signed product terms (six cofactors, the determinant, six
// innovation products and the quadratic form), each built from six 32x32 limb products
// on the single multiplier. The rest is two passes through the shared shift-subtract
// divider, once for NIS = e' adj(S) e / det(S) and once for the window mean; the NIS
// pass is skipped when S is singular or the quadratic form is zero or differs in sign
// from the determinant. A finished result sits in an output register until taken. The
// window memory needs no clearing after reset, since a value read from an entry is only
// subtracted from the sum once the window is full and every entry has been written.
module innovation_consistency_monitor #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [icm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [icm_pkg::NIS_W-1:0]           cfg_data_i,
  // Input item channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [31:0]                  innovation_x_i,
  input  logic signed [31:0]                  innovation_y_i,
  input  logic signed [31:0]                  innovation_z_i,
  input  logic [30:0]                         cov_xx_i,
  input  logic signed [31:0]                  cov_xy_i,
  input  logic signed [31:0]                  cov_xz_i,
  input  logic [30:0]                         cov_yy_i,
  input  logic signed [31:0]                  cov_yz_i,
  input  logic [30:0]                         cov_zz_i,
  // Result item channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [icm_pkg::NIS_W-1:0]           nis_value_o,
  output logic [icm_pkg::NIS_W-1:0]           anis_value_o,
  output logic                                step_alarm_o,
  output logic                                mean_alarm_o,
  output logic                                singular_o
);
  import icm_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = NIS_W + $clog2(WINDOW_DEPTH);

  // Configuration registers.
  logic [30:0]      noise_xx_q, noise_yy_q, noise_zz_q;
  logic [31:0]      noise_xy_q, noise_xz_q, noise_yz_q;
  logic [NIS_W-1:0] nis_limit_q, anis_limit_q;

  // Operand file: S = C + R, innovations, cofactors, innovation products.
  logic signed [S_W-1:0]  sxx_q, sxy_q, sxz_q, syy_q, syz_q, szz_q;
  logic signed [31:0]     ex_q, ey_q, ez_q;
  logic signed [C_W-1:0]  c00_q, c01_q, c02_q, c11_q, c12_q, c22_q;
  logic signed [P_W-1:0]  pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic [ACC_W-1:0]       det_q, num_q;

  state_e                 state_q, state_d;
  logic [TERM_IDX_W-1:0]  term_idx_q;
  term_t                  term_w;
  logic [NIS_W-1:0]       nis_q, anis_q;
  logic                   sing_q;

  logic                   out_valid_q, step_alarm_q, mean_alarm_q, singular_q;
  logic [NIS_W-1:0]       nis_out_q, anis_out_q;

  logic                   in_acc, out_free;
  logic signed [AMAG_W-1:0] mac_a;
  logic signed [BMAG_W-1:0] mac_b;
  mac_cmd_t               mac_cmd;
  logic                   mac_done;
  logic [ACC_W-1:0]       mac_acc;

  logic                   div_start, div_done;
  logic [ACC_W-1:0]       div_num, div_den;
  logic [QUOT_W-1:0]      div_quot;

  win_ctrl_t              win_ctrl;
  logic [SUM_W-1:0]       win_sum;
  logic [FILL_W-1:0]      win_fill;

  logic                   det_neg, num_neg, sing_w, nonpos_w;
  logic [ACC_W-1:0]       dmag, nmag;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign term_w      = term_entry(term_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_xx_q   <= 31'd65536;
      noise_yy_q   <= 31'd65536;
      noise_zz_q   <= 31'd65536;
      noise_xy_q   <= '0;
      noise_xz_q   <= '0;
      noise_yz_q   <= '0;
      nis_limit_q  <= 40'd512164;
      anis_limit_q <= 40'd512164;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NOISE_XX:   noise_xx_q   <= cfg_data_i[30:0];
        CFG_NOISE_XY:   noise_xy_q   <= cfg_data_i[31:0];
        CFG_NOISE_XZ:   noise_xz_q   <= cfg_data_i[31:0];
        CFG_NOISE_YY:   noise_yy_q   <= cfg_data_i[30:0];
        CFG_NOISE_YZ:   noise_yz_q   <= cfg_data_i[31:0];
        CFG_NOISE_ZZ:   noise_zz_q   <= cfg_data_i[30:0];
        CFG_NIS_LIMIT:  nis_limit_q  <= cfg_data_i;
        CFG_ANIS_LIMIT: anis_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (term_w.a_sel)
      OP_SXX:  mac_a = AMAG_W'(sxx_q);
      OP_SXY:  mac_a = AMAG_W'(sxy_q);
      OP_SXZ:  mac_a = AMAG_W'(sxz_q);
      OP_SYY:  mac_a = AMAG_W'(syy_q);
      OP_SYZ:  mac_a = AMAG_W'(syz_q);
      OP_SZZ:  mac_a = AMAG_W'(szz_q);
      OP_EX:   mac_a = AMAG_W'(ex_q);
      OP_EY:   mac_a = AMAG_W'(ey_q);
      OP_EZ:   mac_a = AMAG_W'(ez_q);
      OP_C00:  mac_a = AMAG_W'(c00_q);
      OP_C01:  mac_a = AMAG_W'(c01_q);
      OP_C02:  mac_a = AMAG_W'(c02_q);
      OP_C11:  mac_a = AMAG_W'(c11_q);
      OP_C12:  mac_a = AMAG_W'(c12_q);
      OP_C22:  mac_a = AMAG_W'(c22_q);
      default: mac_a = '0;
    endcase
    unique case (term_w.b_sel)
      OP_SXX:  mac_b = BMAG_W'(sxx_q);
      OP_SXY:  mac_b = BMAG_W'(sxy_q);
      OP_SXZ:  mac_b = BMAG_W'(sxz_q);
      OP_SYY:  mac_b = BMAG_W'(syy_q);
      OP_SYZ:  mac_b = BMAG_W'(syz_q);
      OP_SZZ:  mac_b = BMAG_W'(szz_q);
      OP_EX:   mac_b = BMAG_W'(ex_q);
      OP_EY:   mac_b = BMAG_W'(ey_q);
      OP_EZ:   mac_b = BMAG_W'(ez_q);
      OP_PXX:  mac_b = pxx_q;
      OP_PYY:  mac_b = pyy_q;
      OP_PZZ:  mac_b = pzz_q;
      OP_PXY:  mac_b = pxy_q;
      OP_PXZ:  mac_b = pxz_q;
      OP_PYZ:  mac_b = pyz_q;
      default: mac_b = '0;
    endcase
  end

  assign mac_cmd.start = (state_q == ST_TERM_START);
  assign mac_cmd.neg   = term_w.neg;
  assign mac_cmd.dbl   = term_w.dbl;
  assign mac_cmd.first = term_w.first;

  // Sign and magnitude of the determinant and the quadratic form.
  assign det_neg  = det_q[ACC_W-1];
  assign num_neg  = num_q[ACC_W-1];
  assign dmag     = det_neg ? (~det_q + ACC_W'(1)) : det_q;
  assign nmag     = num_neg ? (~num_q + ACC_W'(1)) : num_q;
  assign sing_w   = (dmag <= DET_EPS_RAW);
  // A zero form or one whose sign differs from the determinant gives NIS of zero, unless S is singular.
  assign nonpos_w = (num_q == '0) || (num_neg != det_neg);

  assign div_start = (state_q == ST_CHECK && !sing_w && !nonpos_w) ||
                     (state_q == ST_AVG_START);
  assign div_num   = (state_q == ST_AVG_START) ? ACC_W'(win_sum) : nmag;
  assign div_den   = (state_q == ST_AVG_START) ? ACC_W'(win_fill) : dmag;

  assign win_ctrl.rd = (state_q == ST_WIN_READ);
  assign win_ctrl.wr = (state_q == ST_WIN_WRITE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_acc) state_d = ST_TERM_START;
      ST_TERM_START: state_d = ST_TERM_WAIT;
      ST_TERM_WAIT:  if (mac_done) state_d = ST_TERM_NEXT;
      ST_TERM_NEXT: begin
        if (term_idx_q == TERM_IDX_W'(NUM_TERMS - 1)) state_d = ST_CHECK;
        else state_d = ST_TERM_START;
      end
      ST_CHECK: begin
        if (sing_w || nonpos_w) state_d = ST_WIN_READ;
        else state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT:   if (div_done) state_d = ST_WIN_READ;
      ST_WIN_READ:   state_d = ST_WIN_WRITE;
      ST_WIN_WRITE:  state_d = ST_AVG_START;
      ST_AVG_START:  state_d = ST_AVG_WAIT;
      ST_AVG_WAIT:   if (div_done) state_d = ST_FINISH;
      ST_FINISH:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        term_idx_q <= '0;
      end else if (state_q == ST_TERM_NEXT) begin
        term_idx_q <= term_idx_q + TERM_IDX_W'(1);
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sxx_q <= S_W'({1'b0, cov_xx_i}) + S_W'({1'b0, noise_xx_q});
      syy_q <= S_W'({1'b0, cov_yy_i}) + S_W'({1'b0, noise_yy_q});
      szz_q <= S_W'({1'b0, cov_zz_i}) + S_W'({1'b0, noise_zz_q});
      sxy_q <= S_W'(cov_xy_i) + S_W'(signed'(noise_xy_q));
      sxz_q <= S_W'(cov_xz_i) + S_W'(signed'(noise_xz_q));
      syz_q <= S_W'(cov_yz_i) + S_W'(signed'(noise_yz_q));
      ex_q  <= innovation_x_i;
      ey_q  <= innovation_y_i;
      ez_q  <= innovation_z_i;
    end
    if (state_q == ST_TERM_NEXT && term_w.last) begin
      unique case (term_w.dest)
        OP_C00:  c00_q <= C_W'(mac_acc);
        OP_C01:  c01_q <= C_W'(mac_acc);
        OP_C02:  c02_q <= C_W'(mac_acc);
        OP_C11:  c11_q <= C_W'(mac_acc);
        OP_C12:  c12_q <= C_W'(mac_acc);
        OP_C22:  c22_q <= C_W'(mac_acc);
        OP_PXX:  pxx_q <= P_W'(mac_acc);
        OP_PYY:  pyy_q <= P_W'(mac_acc);
        OP_PZZ:  pzz_q <= P_W'(mac_acc);
        OP_PXY:  pxy_q <= P_W'(mac_acc);
        OP_PXZ:  pxz_q <= P_W'(mac_acc);
        OP_PYZ:  pyz_q <= P_W'(mac_acc);
        OP_DET:  det_q <= mac_acc;
        OP_NUM:  num_q <= mac_acc;
        default: ;
      endcase
    end
    if (state_q == ST_CHECK) begin
      sing_q <= sing_w;
      if (sing_w) begin
        nis_q <= SINGULAR_NIS;
      end else if (nonpos_w) begin
        nis_q <= '0;
      end
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      nis_q <= div_quot;
    end
    if (state_q == ST_AVG_WAIT && div_done) begin
      anis_q <= div_quot;
    end
    if (state_q == ST_FINISH && out_free) begin
      nis_out_q    <= nis_q;
      anis_out_q   <= anis_q;
      step_alarm_q <= (nis_q > nis_limit_q);
      mean_alarm_q <= (anis_q > anis_limit_q);
      singular_q   <= sing_q;
    end
  end

  icm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  icm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  icm_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .nis_i  (nis_q),
    .sum_o  (win_sum),
    .fill_o (win_fill)
  );

  assign out_valid_o  = out_valid_q;
  assign nis_value_o  = nis_out_q;
  assign anis_value_o = anis_out_q;
  assign step_alarm_o = step_alarm_q;
  assign mean_alarm_o = mean_alarm_q;
  assign singular_o   = singular_q;

  // The per-item alarm agrees with the delivered NIS and the threshold.
  a_step_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (step_alarm_o == (nis_value_o > nis_limit_q)))
    else $error("step alarm disagrees with nis value");

  // A singular result always carries the forced NIS value.
  a_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (nis_value_o == SINGULAR_NIS))
    else $error("singular result without forced nis");

  // A new result only appears after the sequencer finished an item.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish state");

endmodule
